// ----- sv/btc_pkg.sv -----
package btc_pkg;

  localparam int MAX_BLOCK = 16;
  localparam int AW        = $clog2(MAX_BLOCK);
  localparam int LW        = $clog2(MAX_BLOCK + 1);
  localparam int KW        = 4;

  localparam logic [7:0] CHAR_PAD = 8'h5F;
  localparam logic [7:0] CHAR_UA  = 8'h41;
  localparam logic [7:0] CHAR_UZ  = 8'h5A;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_LZ  = 8'h7A;

  localparam logic [1:0] REG_BLOCK_LEN = 2'd0;
  localparam logic [1:0] REG_KEY_MAP   = 2'd1;
  localparam logic [1:0] REG_DECRYPT   = 2'd2;

  // front to queue: letter write and block commit
  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [7:0]    data;
    logic          commit;
    logic [LW-1:0] fill;
    logic          last;
  } btc_wr_t;

  // queue status seen by front and back
  typedef struct packed {
    logic          rd_valid;
    logic [LW-1:0] rd_fill;
    logic          rd_last;
    logic          wr_free;
  } btc_qstat_t;

  function automatic logic [LW-1:0] eff_len(input logic [4:0] len);
    if (len == 5'd0) begin
      return LW'(1);
    end else if (int'(len) > MAX_BLOCK) begin
      return LW'(MAX_BLOCK);
    end else begin
      return LW'(len);
    end
  endfunction

  function automatic logic [KW-1:0] key_entry(input logic [63:0] key, input logic [AW-1:0] j);
    return key[KW*j +: KW];
  endfunction

endpackage

// ----- sv/btc_front.sv -----
module btc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [7:0]             text_byte,
  input  logic                   end_of_message,
  input  logic [btc_pkg::LW-1:0] len,
  input  btc_pkg::btc_qstat_t    qstat,
  output logic                   full,
  output btc_pkg::btc_wr_t       wr
);

  logic [btc_pkg::LW-1:0] fill, fill_next, fill_new;
  logic                   is_lower, is_upper, letter, room, accept;
  logic [7:0]             up;

  always_comb begin
    is_lower = (text_byte >= btc_pkg::CHAR_LA) && (text_byte <= btc_pkg::CHAR_LZ);
    is_upper = (text_byte >= btc_pkg::CHAR_UA) && (text_byte <= btc_pkg::CHAR_UZ);
    letter   = is_lower || is_upper;
    up       = is_lower ? text_byte - (btc_pkg::CHAR_LA - btc_pkg::CHAR_UA) : text_byte;
    accept   = push && qstat.wr_free;
    room     = fill < btc_pkg::LW'(btc_pkg::MAX_BLOCK);
    fill_new = (letter && room) ? fill + btc_pkg::LW'(1) : fill;

    wr.we     = accept && letter && room;
    wr.addr   = fill[btc_pkg::AW-1:0];
    wr.data   = up;
    // block goes out when full (over-full if len drops) or at message end if non-empty
    wr.commit = accept && ((fill_new >= len) || (end_of_message && (fill_new != '0)));
    wr.fill   = fill_new;
    wr.last   = end_of_message;

    if (!accept) begin
      fill_next = fill;
    end else if (wr.commit) begin
      fill_next = '0;
    end else begin
      fill_next = fill_new;
    end

    full = !qstat.wr_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

// ----- sv/btc_queue.sv -----
module btc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  btc_pkg::btc_wr_t       wr,
  input  logic                   release_blk,
  input  logic [btc_pkg::AW-1:0] rd_addr,
  output btc_pkg::btc_qstat_t    qstat,
  output logic [7:0]             rd_data
);

  logic [7:0]             buffer [2][btc_pkg::MAX_BLOCK];
  logic [btc_pkg::LW-1:0] slot_fill [2];
  logic                   slot_last [2];
  logic                   wr_slot, rd_slot;
  logic [1:0]             count;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      buffer[wr_slot][wr.addr] <= wr.data;
    end
    if (wr.commit) begin
      slot_fill[wr_slot] <= wr.fill;
      slot_last[wr_slot] <= wr.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_slot <= 1'b0;
      rd_slot <= 1'b0;
      count   <= 2'd0;
    end else begin
      if (wr.commit) begin
        wr_slot <= ~wr_slot;
      end
      if (release_blk) begin
        rd_slot <= ~rd_slot;
      end
      unique case ({wr.commit, release_blk})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_comb begin
    qstat.rd_valid = count != 2'd0;
    qstat.rd_fill  = slot_fill[rd_slot];
    qstat.rd_last  = slot_last[rd_slot];
    qstat.wr_free  = count != 2'd2;
    rd_data        = buffer[rd_slot][rd_addr];
  end

endmodule

// ----- sv/btc_back.sv -----
module btc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [btc_pkg::LW-1:0] len,
  input  logic [63:0]            key_map,
  input  logic                   decrypt_mode,
  input  btc_pkg::btc_qstat_t    qstat,
  input  logic [7:0]             rd_data,
  input  logic                   pop,
  output logic [btc_pkg::AW-1:0] rd_addr,
  output logic                   release_blk,
  output logic                   empty,
  output logic [7:0]             cipher_byte,
  output logic                   final_byte
);

  logic [btc_pkg::AW-1:0] pos;
  logic                   ovalid;
  logic [btc_pkg::AW-1:0] src;
  logic                   ok, last_pos, advance;
  logic [btc_pkg::KW-1:0] k;
  logic [7:0]             byte_out;

  always_comb begin
    src = '0;
    ok  = 1'b0;
    k   = btc_pkg::key_entry(key_map, pos);
    if (decrypt_mode) begin
      // inverse key: last entry in range that names this position wins
      for (int j = 0; j < btc_pkg::MAX_BLOCK; j++) begin
        if ((btc_pkg::LW'(j) < len) &&
            (btc_pkg::key_entry(key_map, btc_pkg::AW'(j)) == btc_pkg::KW'(pos))) begin
          src = btc_pkg::AW'(j);
          ok  = 1'b1;
        end
      end
    end else begin
      src = btc_pkg::AW'(k);
      ok  = btc_pkg::LW'(k) < len;
    end
    rd_addr = src;
    // unmapped positions and those past the held letters are padding
    byte_out = (ok && (btc_pkg::LW'(src) < qstat.rd_fill)) ? rd_data : btc_pkg::CHAR_PAD;

    last_pos    = (btc_pkg::LW'(pos) + btc_pkg::LW'(1)) == len;
    advance     = qstat.rd_valid && (!ovalid || pop);
    release_blk = advance && last_pos;
    empty       = !ovalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      pos    <= '0;
    end else if (advance) begin
      ovalid <= 1'b1;
      pos    <= last_pos ? '0 : pos + btc_pkg::AW'(1);
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cipher_byte <= byte_out;
      final_byte  <= qstat.rd_last && last_pos;
    end
  end

endmodule

// ----- sv/block_transposition_cipher_core.sv -----
// output: once a committed block is counted in the queue and the result ports are free,
//   its first byte is registered onto them, then one byte per cycle while pop keeps up
// throughput: one text byte per cycle while one of the two block slots is free; output
//   one byte per cycle while pop keeps up, and a block frees its slot with its last byte
// reset: synchronous, clears fill count, slot pointers and output valid; block_len 1,
//   key_map 0, decrypt_mode 0; block buffers are not cleared
module block_transposition_cipher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  cipher_byte,
  output logic        final_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [4:0]             block_len;
  logic [63:0]            key_map;
  logic                   decrypt_mode;
  logic [btc_pkg::LW-1:0] len;
  btc_pkg::btc_wr_t       wr;
  btc_pkg::btc_qstat_t    qstat;
  logic                   release_blk;
  logic [btc_pkg::AW-1:0] rd_addr;
  logic [7:0]             rd_data;

  assign cfg_ready = 1'b1;
  assign len       = btc_pkg::eff_len(block_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len    <= 5'd1;
      key_map      <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        btc_pkg::REG_BLOCK_LEN: block_len    <= cfg_data[4:0];
        btc_pkg::REG_KEY_MAP:   key_map      <= cfg_data;
        btc_pkg::REG_DECRYPT:   decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  btc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .text_byte      (text_byte),
    .end_of_message (end_of_message),
    .len            (len),
    .qstat          (qstat),
    .full           (full),
    .wr             (wr)
  );

  btc_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .release_blk (release_blk),
    .rd_addr     (rd_addr),
    .qstat       (qstat),
    .rd_data     (rd_data)
  );

  btc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .len          (len),
    .key_map      (key_map),
    .decrypt_mode (decrypt_mode),
    .qstat        (qstat),
    .rd_data      (rd_data),
    .pop          (pop),
    .rd_addr      (rd_addr),
    .release_blk  (release_blk),
    .empty        (empty),
    .cipher_byte  (cipher_byte),
    .final_byte   (final_byte)
  );

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    wr.commit |-> qstat.wr_free)
    else $error("block committed with both slots busy");

  a_release_valid : assert property (@(posedge clk) disable iff (rst)
    release_blk |-> qstat.rd_valid)
    else $error("slot released with no block queued");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result valid right after reset");

endmodule
